[sv/bmap_pkg.sv]
package bmap_pkg;

   localparam int CRD_W = 9;

   typedef struct packed {
      logic       op;
      logic [7:0] column;
      logic [7:0] row_index;
      logic [7:0] pixel_value;
   } bmap_req_type;

   typedef struct packed {
      logic [7:0] bump_luminance;
      logic [7:0] delta_v;
      logic [7:0] delta_u;
   } bmap_rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en_a;
      logic rd_en_b;
      logic zero_a;
      logic zero_b;
   } bmap_mem_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2
   } bmap_state_type;

   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [CRD_W-1:0] SIZE_RESET = 9'd256;

   localparam logic [7:0] LUMA_HIGH      = 8'd63;
   localparam logic [7:0] LUMA_LOW       = 8'd127;
   localparam logic [7:0] LUMA_THRESHOLD = 8'd1;

endpackage

[sv/bmap_store.sv]
module bmap_store import bmap_pkg::*; #(
   parameter int AW = 16
) (
   input  logic             clock,
   input  bmap_mem_ctl_type ctl,
   input  logic [AW-1:0]    wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [7:0]       rd_data_a,
   output logic [7:0]       rd_data_b
);

   logic [7:0] store_ff [2**AW];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en_a) begin
         rd_a_ff <= ctl.zero_a ? 8'd0 : store_ff[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en_b) begin
         rd_b_ff <= ctl.zero_b ? 8'd0 : store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[sv/bmap_ctrl.sv]
module bmap_ctrl import bmap_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CW         = 8,
   parameter int RW         = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bmap_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bmap_rsp_type          rsp_data,
   input  logic [CRD_W-1:0]      width,
   input  logic [CRD_W-1:0]      height,
   output bmap_mem_ctl_type      mem_ctl,
   output logic [CW+RW-1:0]      wr_addr,
   output logic [7:0]            wr_data,
   output logic [CW+RW-1:0]      rd_addr_a,
   output logic [CW+RW-1:0]      rd_addr_b,
   input  logic [7:0]            rd_data_a,
   input  logic [7:0]            rd_data_b
);

   localparam int AW = CW + RW;
   localparam logic [12:0] WLIM = 13'(MAX_WIDTH);
   localparam logic [12:0] HLIM = 13'(MAX_HEIGHT);

   function automatic logic [AW-1:0] addr_of(logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
      logic [CW+CRD_W-1:0] cx;
      logic [RW+CRD_W-1:0] rx;
      cx = {{CW{1'b0}}, c};
      rx = {{RW{1'b0}}, r};
      return {rx[RW-1:0], cx[CW-1:0]};
   endfunction

   function automatic logic in_store(logic [CRD_W-1:0] c, logic [CRD_W-1:0] r);
      return ({4'd0, c} < WLIM) && ({4'd0, r} < HLIM);
   endfunction

   bmap_state_type     state_ff, state_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bmap_rsp_type       rsp_data_ff, rsp_data_in;
   logic [CRD_W-1:0]   col_ff, col_in;
   logic [CRD_W-1:0]   row_ff, row_in;
   logic [CRD_W-1:0]   left_ff, left_in;
   logic [CRD_W-1:0]   right_ff, right_in;
   logic [CRD_W-1:0]   down_ff, down_in;
   logic [7:0]         luma_ff, luma_in;
   logic [7:0]         above_ff, above_in;
   logic [7:0]         dv_ff, dv_in;
   logic [7:0]         lval_ff, lval_in;

   logic [CRD_W-1:0]   col9, row9, up9;
   logic               accept, out_free, load;

   assign col9 = {1'b0, req_data.column};
   assign row9 = {1'b0, req_data.row_index};
   assign up9  = (row9 != '0) ? row9 - 9'd1 : height - 9'd1;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = pend_ff && out_free;
   assign req_ready = (state_ff == ST_IDLE) && (!pend_ff || out_free);
   assign accept    = req_valid && req_ready;

   assign wr_addr = addr_of(col9, row9);
   assign wr_data = req_data.pixel_value;

   always_comb begin
      state_in  = state_ff;
      mem_ctl   = '0;
      rd_addr_a = addr_of(col9, row9);
      rd_addr_b = addr_of(col9, up9);
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      down_in   = down_ff;
      luma_in   = luma_ff;
      above_in  = above_ff;
      dv_in     = dv_ff;
      lval_in   = lval_ff;
      pend_in   = pend_ff && !load;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_in   = col9;
               row_in   = row9;
               left_in  = (col9 != '0) ? col9 - 9'd1 : width - 9'd1;
               right_in = (col9 < width - 9'd1) ? col9 + 9'd1 : '0;
               down_in  = (row9 < height - 9'd1) ? row9 + 9'd1 : '0;
               if (req_data.op == OP_COMPUTE) begin
                  mem_ctl.rd_en_a = 1'b1;
                  mem_ctl.rd_en_b = 1'b1;
                  mem_ctl.zero_a  = !in_store(col9, row9);
                  mem_ctl.zero_b  = !in_store(col9, up9);
                  state_in        = ST_RD1;
               end else begin
                  mem_ctl.wr_en = in_store(col9, row9);
               end
            end
         end
         ST_RD1: begin
            rd_addr_a       = addr_of(col_ff, down_ff);
            rd_addr_b       = addr_of(left_ff, row_ff);
            mem_ctl.rd_en_a = 1'b1;
            mem_ctl.rd_en_b = 1'b1;
            mem_ctl.zero_a  = !in_store(col_ff, down_ff);
            mem_ctl.zero_b  = !in_store(left_ff, row_ff);
            luma_in  = (rd_data_a > LUMA_THRESHOLD) ? LUMA_HIGH : LUMA_LOW;
            above_in = rd_data_b;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            rd_addr_a       = addr_of(right_ff, row_ff);
            mem_ctl.rd_en_a = 1'b1;
            mem_ctl.zero_a  = !in_store(right_ff, row_ff);
            dv_in    = above_ff - rd_data_a;
            lval_in  = rd_data_b;
            pend_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_data_in.bump_luminance = luma_ff;
         rsp_data_in.delta_v        = dv_ff;
         rsp_data_in.delta_u        = lval_ff - rd_data_a;
         rsp_valid_in               = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      down_ff     <= down_in;
      luma_ff     <= luma_in;
      above_ff    <= above_in;
      dv_ff       <= dv_in;
      lval_ff     <= lval_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/dudv_bump_map_from_height_map.sv]
// Store beat: written to the frame store at the accepting edge.
// Compute beat: five reads through the two read ports of the frame store, issued in ST_IDLE,
// ST_RD1 and ST_RD2; no new request is taken in ST_RD1 or ST_RD2.
// Reset clears the sequencer and output valid and sets both size registers to 256
// (clamped to the maximum); the frame store is not cleared and holds garbage until written.
module dudv_bump_map_from_height_map import bmap_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bmap_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmap_rsp_type     rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CRD_W-1:0] csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = CW + RW;

   localparam logic [CRD_W-1:0] WMAX = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
   localparam logic [CRD_W-1:0] HMAX = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);

   function automatic logic [CRD_W-1:0] clamp_size(logic [CRD_W-1:0] v, logic [CRD_W-1:0] m);
      return (v == '0) ? 9'd1 : ((v > m) ? m : v);
   endfunction

   localparam logic [CRD_W-1:0] WIDTH_RST  = clamp_size(SIZE_RESET, WMAX);
   localparam logic [CRD_W-1:0] HEIGHT_RST = clamp_size(SIZE_RESET, HMAX);

   logic [CRD_W-1:0] width_ff, width_in;
   logic [CRD_W-1:0] height_ff, height_in;

   bmap_mem_ctl_type mem_ctl;
   logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
   logic [7:0]       wr_data, rd_data_a, rd_data_b;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = clamp_size(csr_wdata, WMAX);
            CSR_HEIGHT: height_in = clamp_size(csr_wdata, HMAX);
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   bmap_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .width     (width_ff),
      .height    (height_ff),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bmap_store #(
      .AW (AW)
   ) u_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

`ifndef SYNTHESIS
   a_compute_holds_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.op == OP_COMPUTE) |=> !req_ready ##1 !req_ready)
      else $error("input taken during compute reads");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   a_size_legal: assert property (@(posedge clock) disable iff (reset)
      (width_ff != '0) && (width_ff <= WMAX) && (height_ff != '0) && (height_ff <= HMAX))
      else $error("size register outside clamped range");
`endif

endmodule

[tb/dudv_bump_map_checker.sv]
module dudv_bump_map_checker import bmap_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bmap_req_type     req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bmap_rsp_type     rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_index,
   input  logic [CRD_W-1:0] csr_wdata,
   output int               fail_count,
   output int               results_owed
);

   logic [7:0]       height_map [MAX_WIDTH*MAX_HEIGHT];
   logic [CRD_W-1:0] width_reg;
   logic [CRD_W-1:0] height_reg;
   bmap_rsp_type     owed_texels [$];
   int               mismatches;

   initial begin
      fail_count   = 0;
      results_owed = 0;
      mismatches   = 0;
   end

   function automatic logic [7:0] pixel_at(input int c, input int r);
      if (c >= MAX_WIDTH || r >= MAX_HEIGHT) begin
         return 8'd0;
      end
      return height_map[r * MAX_WIDTH + c];
   endfunction

   function automatic int clamp_size(input logic [CRD_W-1:0] v, input int maxv);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > maxv) begin
         return maxv;
      end
      return int'(v);
   endfunction

   function automatic bmap_rsp_type predict_texel(input int c, input int r);
      int           w;
      int           h;
      int           lc;
      int           rc;
      int           ur;
      int           dr;
      bmap_rsp_type t;
      w  = clamp_size(width_reg, MAX_WIDTH);
      h  = clamp_size(height_reg, MAX_HEIGHT);
      lc = (c > 0) ? c - 1 : w - 1;
      rc = (c < w - 1) ? c + 1 : 0;
      ur = (r > 0) ? r - 1 : h - 1;
      dr = (r < h - 1) ? r + 1 : 0;
      t.bump_luminance = (pixel_at(c, r) > LUMA_THRESHOLD) ? LUMA_HIGH : LUMA_LOW;
      t.delta_v        = pixel_at(c, ur) - pixel_at(c, dr);
      t.delta_u        = pixel_at(lc, r) - pixel_at(rc, r);
      return t;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bmap_rsp_type want;
      if (reset) begin
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         owed_texels.delete();
      end else begin
         // retire before predicting: a texel cannot leave on its own accepting edge
         if (rsp_valid && rsp_ready) begin
            if (owed_texels.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = owed_texels.pop_front();
               check_field("bump_luminance", want.bump_luminance, rsp_data.bump_luminance);
               check_field("delta_v", want.delta_v, rsp_data.delta_v);
               check_field("delta_u", want.delta_u, rsp_data.delta_u);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) begin
               width_reg = csr_wdata;
            end else begin
               height_reg = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.op == OP_COMPUTE) begin
               owed_texels.push_back(predict_texel(req_data.column, req_data.row_index));
            end else if (int'(req_data.column) < MAX_WIDTH &&
                         int'(req_data.row_index) < MAX_HEIGHT) begin
               height_map[int'(req_data.row_index) * MAX_WIDTH + int'(req_data.column)] =
                  req_data.pixel_value;
            end
         end
      end
      fail_count   <= mismatches;
      results_owed <= owed_texels.size();
   end

endmodule

[tb/dudv_bump_map_from_height_map_test.sv]
module dudv_bump_map_from_height_map_test;
   import bmap_pkg::*;

   localparam int MAP_DIM     = 256;
   localparam int ITEM_TARGET = 1800;
   localparam int QUIET_TAIL  = 1500;
   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE      = 6;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bmap_req_type     req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bmap_rsp_type     rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [CRD_W-1:0] csr_wdata;
   int               fail_count;
   int               results_owed;

   bit               written [MAP_DIM*MAP_DIM];
   bit               idling;
   int               ew;
   int               eh;
   int               n_items;
   int               n_stores;
   int               n_computes;
   int               n_sizes;

   dudv_bump_map_from_height_map i_dut (.*);

   dudv_bump_map_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   function automatic int size_in_use(input logic [CRD_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > MAP_DIM) begin
         return MAP_DIM;
      end
      return int'(v);
   endfunction

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_coord(input int extent);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return extent - 1;
         2: return (extent < MAP_DIM) ? $urandom_range(extent, MAP_DIM - 1) : MAP_DIM - 1;
         default: return $urandom_range(0, extent - 1);
      endcase
   endfunction

   function automatic logic [CRD_W-1:0] pick_size();
      case ($urandom_range(0, 5))
         0: return CRD_W'($urandom);
         1: return CRD_W'($urandom_range(1, MAP_DIM));
         default: return CRD_W'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic send_item(input logic op, input int c, input int r, input logic [7:0] v);
      bmap_req_type item;
      item.op          = op;
      item.column      = c[7:0];
      item.row_index   = r[7:0];
      item.pixel_value = v;
      if (n_items >= QUIET_TAIL) begin
         idling = 1'b0;
      end
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      n_items++;
   endtask

   task automatic store_at(input int c, input int r, input logic [7:0] v);
      send_item(OP_STORE, c, r, v);
      written[r * MAP_DIM + c] = 1'b1;
      n_stores++;
   endtask

   task automatic compute_at(input int c, input int r);
      int xs [5];
      int ys [5];
      int lc;
      int rc;
      int ur;
      int dr;
      lc = (c > 0) ? c - 1 : ew - 1;
      rc = (c < ew - 1) ? c + 1 : 0;
      ur = (r > 0) ? r - 1 : eh - 1;
      dr = (r < eh - 1) ? r + 1 : 0;
      xs = '{c, lc, rc, c, c};
      ys = '{r, r, r, ur, dr};
      // fill the texel itself and any neighbor never written yet
      for (int k = 0; k < 5; k++) begin
         if (!written[ys[k] * MAP_DIM + xs[k]]) begin
            store_at(xs[k], ys[k], pick_pixel());
         end
      end
      send_item(OP_COMPUTE, c, r, 8'($urandom));
      n_computes++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_size(input logic [CRD_W-1:0] wv, input logic [CRD_W-1:0] hv);
      csr_valid <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= wv;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= hv;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ew = size_in_use(wv);
      eh = size_in_use(hv);
      n_sizes++;
   endtask

   initial begin
      logic [CRD_W-1:0] fixed_w [6];
      logic [CRD_W-1:0] fixed_h [6];
      int               phase;
      fixed_w = '{9'd1, 9'd0, 9'd2, 9'd511, 9'd256, 9'd1};
      fixed_h = '{9'd1, 9'd0, 9'd3, 9'd257, 9'd1, 9'd256};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_WIDTH;
      csr_wdata <= '0;
      idling     = 1'b1;
      ew         = MAP_DIM;
      eh         = MAP_DIM;
      n_items    = 0;
      n_stores   = 0;
      n_computes = 0;
      n_sizes    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corners and interior points of the full-size image under the reset sizes
      store_at(0, 0, 8'd2);
      store_at(1, 0, 8'd0);
      store_at(255, 0, 8'd255);
      store_at(0, 1, 8'd1);
      store_at(0, 255, 8'd128);
      compute_at(0, 0);
      store_at(255, 255, 8'd1);
      store_at(254, 255, 8'd0);
      store_at(255, 254, 8'd255);
      compute_at(255, 255);
      compute_at(1, 0);
      compute_at(128, 127);

      phase = 0;
      while (n_items < ITEM_TARGET) begin
         drain();
         if (phase < 6) begin
            set_size(fixed_w[phase], fixed_h[phase]);
         end else begin
            set_size(pick_size(), pick_size());
         end
         idling = (n_items < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         repeat ((ew * eh > 64) ? 40 : 120) begin
            if ($urandom_range(0, 2) == 0) begin
               store_at(pick_coord(ew), pick_coord(eh), pick_pixel());
            end else begin
               compute_at(pick_coord(ew), pick_coord(eh));
            end
         end
         phase++;
      end
      drain();

      $display("covered %0d store beats and %0d texel computes", n_stores, n_computes);
      $display("over %0d image size settings, edge wrap and out-of-range sizes included",
               n_sizes);
      if (fail_count == 0 && results_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
sv/bmap_pkg.sv
sv/bmap_store.sv
sv/bmap_ctrl.sv
sv/dudv_bump_map_from_height_map.sv
tb/dudv_bump_map_checker.sv
tb/dudv_bump_map_from_height_map_test.sv
